@@ rtl/fbc_pkg.sv @@
// Shared types, codes and constants of the framebuffer blit and format convert unit.
// No dependencies; every other file imports this package.
package fbc_pkg;

	// Item kinds as carried in the input tuser field
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_BLIT  = 2'd3
	} kind_t;

	// Blit source byte orders; higher codes are invalid and write nothing
	localparam logic [2:0] FMT_RGBA = 3'd0;
	localparam logic [2:0] FMT_BGRA = 3'd1;
	localparam logic [2:0] FMT_RGB  = 3'd2;
	localparam logic [2:0] FMT_BGR  = 3'd3;

	// Configuration register indexes (byte address bit 2)
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam int   PADDR_W    = 3;

	// Field and datapath widths
	localparam int DIM_W   = 10;  // buffer width, height, positions, counters
	localparam int COORD_W = 11;  // origin plus counter
	localparam int IW_W    = 11;  // image width field
	localparam int PROD_W  = 21;  // row times width
	localparam int IDX_W   = 22;  // linear pixel index
	localparam int SIZE_W  = 20;  // width times height
	localparam int PIX_W   = 32;

	localparam logic [7:0]      ALPHA_OPAQUE = 8'hFF;
	localparam logic [IW_W-1:0] IMG_W_MAX    = 11'd1024;

	// Output queue
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_AW    = 3;
	localparam int OCNT_W      = 4;

	// Memory access presented by the address stage
	typedef struct packed {
		logic              vld;
		kind_t             kind;
		logic              wr_en;
		logic              in_range;
		logic [IDX_W-1:0]  idx;
		logic [SIZE_W-1:0] size;
		logic [PIX_W-1:0]  pixel;
	} acc_t;

	// Occupancy of the address stages
	typedef struct packed {
		logic rd_s1;
		logic rd_s2;
		logic clr_s1;
		logic clr_s2;
	} pipe_sts_t;

	// Read response leaving the store
	typedef struct packed {
		logic             vld;
		logic             oor;
		logic [PIX_W-1:0] pixel;
	} rsp_t;

	// Pack channels into the stored RGBA8888 word, red lowest
	function automatic logic [PIX_W-1:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		pack_pixel = {a, b, g, r};
	endfunction

endpackage

@@ rtl/fbc_addr.sv @@
// Address stages: blit column/row walk, byte-order conversion and linear index.
// Depends on fbc_pkg.
module fbc_addr import fbc_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  kind_t             kind,
	input  logic [DIM_W-1:0]  pos_x,
	input  logic [DIM_W-1:0]  pos_y,
	input  logic [7:0]        byte_zero,
	input  logic [7:0]        byte_one,
	input  logic [7:0]        byte_two,
	input  logic [7:0]        byte_three,
	input  logic [2:0]        source_format,
	input  logic [IW_W-1:0]   image_width,
	input  logic [DIM_W-1:0]  origin_x,
	input  logic [DIM_W-1:0]  origin_y,
	input  logic              last_pixel,
	input  logic [DIM_W-1:0]  buf_width,
	input  logic [DIM_W-1:0]  buf_height,
	output acc_t              acc,
	output pipe_sts_t         sts
);

	logic [DIM_W-1:0]   col_q, row_q;
	logic [IW_W-1:0]    iw_c;
	logic [IW_W-1:0]    col_next;
	logic [COORD_W-1:0] x_c, y_c;
	logic [PIX_W-1:0]   pixel_c;
	logic               wr_en_c;

	logic               vld_s1, wr_en_s1;
	kind_t              kind_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [PIX_W-1:0]   pixel_s1;
	logic [DIM_W-1:0]   eff_w, eff_h;

	logic               vld_s2, wr_en_s2;
	kind_t              kind_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic [COORD_W-1:0] x_s2;
	logic [SIZE_W-1:0]  size_s2;
	logic [PIX_W-1:0]   pixel_s2;

	// Clamp image width to 1..1024
	always_comb begin
		if (image_width == '0) begin
			iw_c = IW_W'(1);
		end else if (image_width > IMG_W_MAX) begin
			iw_c = IMG_W_MAX;
		end else begin
			iw_c = image_width;
		end
		col_next = IW_W'(col_q) + IW_W'(1);
	end

	// Advance the blit walk on each blit item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire && kind == KIND_BLIT) begin
			if (last_pixel) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_next >= iw_c) begin
				col_q <= '0;
				row_q <= row_q + DIM_W'(1);
			end else begin
				col_q <= col_next[DIM_W-1:0];
			end
		end
	end

	// Form target coordinates and the stored word
	always_comb begin
		x_c     = {1'b0, pos_x};
		y_c     = {1'b0, pos_y};
		pixel_c = pack_pixel(byte_zero, byte_one, byte_two, byte_three);
		wr_en_c = 1'b0;
		case (kind)
			KIND_WRITE: wr_en_c = 1'b1;
			KIND_BLIT: begin
				x_c = COORD_W'(origin_x) + COORD_W'(col_q);
				y_c = COORD_W'(origin_y) + COORD_W'(row_q);
				wr_en_c = 1'b1;
				case (source_format)
					FMT_RGBA: pixel_c = pack_pixel(byte_zero, byte_one, byte_two, byte_three);
					FMT_BGRA: pixel_c = pack_pixel(byte_two, byte_one, byte_zero, byte_three);
					FMT_RGB:  pixel_c = pack_pixel(byte_zero, byte_one, byte_two, ALPHA_OPAQUE);
					FMT_BGR:  pixel_c = pack_pixel(byte_two, byte_one, byte_zero, ALPHA_OPAQUE);
					default:  wr_en_c = 1'b0;
				endcase
			end
			default: wr_en_c = 1'b0;
		endcase
	end

	// Stage 1: capture the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= kind;
			wr_en_s1 <= wr_en_c;
			x_s1     <= x_c;
			y_s1     <= y_c;
			pixel_s1 <= pixel_c;
		end
	end

	// Saturate the buffer size to the memory bounds
	always_comb begin
		eff_w = (32'(buf_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : buf_width;
		eff_h = (32'(buf_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : buf_height;
	end

	// Stage 2: row offset and buffer size products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			kind_s2  <= kind_s1;
			wr_en_s2 <= wr_en_s1;
			prod_s2  <= PROD_W'(y_s1) * PROD_W'(eff_w);
			size_s2  <= SIZE_W'(eff_w) * SIZE_W'(eff_h);
			x_s2     <= x_s1;
			pixel_s2 <= pixel_s1;
		end
	end

	// Linear index and range check toward the memory
	always_comb begin
		acc.vld      = vld_s2;
		acc.kind     = kind_s2;
		acc.wr_en    = wr_en_s2;
		acc.idx      = IDX_W'(prod_s2) + IDX_W'(x_s2);
		acc.in_range = acc.idx < IDX_W'(size_s2);
		acc.size     = size_s2;
		acc.pixel    = pixel_s2;
	end

	assign sts.rd_s1  = vld_s1 && kind_s1 == KIND_READ;
	assign sts.rd_s2  = vld_s2 && kind_s2 == KIND_READ;
	assign sts.clr_s1 = vld_s1 && kind_s1 == KIND_CLEAR;
	assign sts.clr_s2 = vld_s2 && kind_s2 == KIND_CLEAR;

endmodule

@@ rtl/fbc_store.sv @@
// Pixel memory with one write and one registered read port, plus the clear sweep.
// Depends on fbc_pkg.
module fbc_store import fbc_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  acc_t acc,
	output rsp_t rsp,
	output logic sweep_busy
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [PIX_W-1:0]  mem_q [DEPTH];
	logic [PIX_W-1:0]  rdata_s3;
	logic              vld_s3, oor_s3;

	logic              sweep_q;
	logic [SIZE_W-1:0] sweep_cnt_q, sweep_last_q;
	logic [PIX_W-1:0]  sweep_pix_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [PIX_W-1:0]  mem_wdata;

	// Sweep owns the write port; items are held off meanwhile
	always_comb begin
		mem_raddr = AW'(acc.idx);
		if (sweep_q) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(sweep_cnt_q);
			mem_wdata = sweep_pix_q;
		end else begin
			mem_we    = acc.vld && acc.wr_en && acc.in_range;
			mem_waddr = AW'(acc.idx);
			mem_wdata = acc.pixel;
		end
	end

	// Memory array
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_s3 <= mem_q[mem_raddr];
	end

	// Walk every entry of the buffer after a clear item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b0;
		end else if (sweep_q) begin
			if (sweep_cnt_q == sweep_last_q) begin
				sweep_q <= 1'b0;
			end
		end else if (acc.vld && acc.kind == KIND_CLEAR && acc.size != '0) begin
			sweep_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + SIZE_W'(1);
		end else if (acc.vld && acc.kind == KIND_CLEAR) begin
			sweep_cnt_q  <= '0;
			sweep_last_q <= acc.size - SIZE_W'(1);
			sweep_pix_q  <= acc.pixel;
		end
	end

	// Stage 3: read response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= acc.vld && acc.kind == KIND_READ;
		end
	end

	always_ff @(posedge clk) begin
		oor_s3 <= !acc.in_range;
	end

	assign rsp.vld    = vld_s3;
	assign rsp.oor    = oor_s3;
	assign rsp.pixel  = oor_s3 ? '0 : rdata_s3;
	assign sweep_busy = sweep_q;

endmodule

@@ rtl/framebuffer_blit_format_convert_unit.sv @@
// RGBA8888 framebuffer with pixel write, pixel read, clear and format-converting blit.
// Writes, reads and blit pixels enter one per cycle while intake is open. A read goes
// through the address stages and the memory read stage into an 8-entry output queue;
// intake pauses while 8 reads are outstanding or a clear is in the address stages or
// sweeps the single memory write port. Memory contents are undefined after reset until
// written; there is no clearing pass. Depends on fbc_pkg, fbc_addr and fbc_store.
module framebuffer_blit_format_convert_unit import fbc_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Input items
	input  logic               s_tvalid,
	output logic               s_tready,
	// pos_x[9:0] pos_y[19:10] byte_zero[27:20] byte_one[35:28] byte_two[43:36]
	// byte_three[51:44] source_format[54:52] image_width[65:55] origin_x[75:66]
	// origin_y[85:76], zero pad [87:86]
	input  logic [87:0]        s_tdata,
	// kind[1:0]
	input  logic [1:0]         s_tuser,
	// last_pixel
	input  logic               s_tlast,
	// Result items
	output logic               m_tvalid,
	input  logic               m_tready,
	// red[7:0] green[15:8] blue[23:16] alpha[31:24]
	output logic [31:0]        m_tdata,
	// out_of_range[0]
	output logic [0:0]         m_tuser
);

	logic [DIM_W-1:0]    width_q, height_q;
	logic                cfg_wr;
	logic                in_fire, busy;
	acc_t                acc;
	pipe_sts_t           sts;
	rsp_t                rsp;
	logic                sweep_busy;

	logic [PIX_W:0]      fifo_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCNT_W-1:0]   cnt_q, pending;
	logic                push, pop;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Intake: hold while clearing or when the output queue could overflow
	assign pending  = cnt_q + OCNT_W'(sts.rd_s1) + OCNT_W'(sts.rd_s2) + OCNT_W'(rsp.vld);
	assign busy     = sts.clr_s1 || sts.clr_s2 || sweep_busy;
	assign s_tready = !busy && pending < OCNT_W'(OFIFO_DEPTH);
	assign in_fire  = s_tvalid && s_tready;

	fbc_addr #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_addr (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.kind          (kind_t'(s_tuser)),
		.pos_x         (s_tdata[9:0]),
		.pos_y         (s_tdata[19:10]),
		.byte_zero     (s_tdata[27:20]),
		.byte_one      (s_tdata[35:28]),
		.byte_two      (s_tdata[43:36]),
		.byte_three    (s_tdata[51:44]),
		.source_format (s_tdata[54:52]),
		.image_width   (s_tdata[65:55]),
		.origin_x      (s_tdata[75:66]),
		.origin_y      (s_tdata[85:76]),
		.last_pixel    (s_tlast),
		.buf_width     (width_q),
		.buf_height    (height_q),
		.acc           (acc),
		.sts           (sts)
	);

	fbc_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.rsp        (rsp),
		.sweep_busy (sweep_busy)
	);

	// Output queue
	assign push = rsp.vld;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {rsp.oor, rsp.pixel};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OFIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OFIFO_AW'(1);
			end
			cnt_q <= cnt_q + OCNT_W'(push) - OCNT_W'(pop);
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = fifo_q[rd_ptr_q][PIX_W-1:0];
	assign m_tuser  = fifo_q[rd_ptr_q][PIX_W];

	// Queue never overflows
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < OCNT_W'(OFIFO_DEPTH))
		else $error("output queue overflow");

	// Outstanding reads stay within the queue depth
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending <= OCNT_W'(OFIFO_DEPTH))
		else $error("too many reads outstanding");

	// No item is taken while the clear sweep owns the memory
	a_sweep_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_busy |-> !s_tready)
		else $error("item taken during clear sweep");

	// A clear item closes intake in the next cycle
	a_clear_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_tuser == KIND_CLEAR |=> !s_tready)
		else $error("intake open behind clear");

endmodule
